/* src/chm_pkg.sv */
// Shared types and constants of the contraharmonic mean accumulator.
package chm_pkg;

  localparam int unsigned NumW     = 46;
  localparam int unsigned DenW     = 38;
  localparam int unsigned PixW     = 8;
  localparam int unsigned PowW     = 32;
  localparam int unsigned TblDepth = 256;
  localparam int unsigned CfgW     = 3;
  localparam int unsigned NumLanes = 4;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_TABLE = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_OUTPUT
  } div_state_e;

  // Control travelling from the front end to every lane.
  typedef struct packed {
    logic lane_en;
    logic clear;
  } lane_ctrl_t;

endpackage

/* src/chm_if.sv */
// Valid/ready channel interfaces of the contraharmonic mean accumulator.
interface chm_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  table_index;
  logic [31:0] table_value;
  logic [7:0]  sample_ch0;
  logic [7:0]  sample_ch1;
  logic [7:0]  sample_ch2;
  logic [7:0]  sample_ch3;
  logic        window_end;
  modport source (output valid, req_type, table_index, table_value, sample_ch0,
                  sample_ch1, sample_ch2, sample_ch3, window_end, input ready);
  modport sink (input valid, req_type, table_index, table_value, sample_ch0,
                sample_ch1, sample_ch2, sample_ch3, window_end, output ready);
endinterface

interface chm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mean_ch0;
  logic [7:0] mean_ch1;
  logic [7:0] mean_ch2;
  logic [7:0] mean_ch3;
  modport source (output valid, mean_ch0, mean_ch1, mean_ch2, mean_ch3, input ready);
  modport sink (input valid, mean_ch0, mean_ch1, mean_ch2, mean_ch3, output ready);
endinterface

interface chm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* src/chm_lane.sv */
// One channel lane: power table lookup, product, saturating sums and a
// restoring divider that yields one quotient bit per cycle of div_step_i.
module chm_lane import chm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tbl_we_i,
  input  logic [PixW-1:0]     tbl_idx_i,
  input  logic [PowW-1:0]     tbl_val_i,
  input  logic                pix_v_i,
  input  logic [PixW-1:0]     pix_i,
  input  lane_ctrl_t          ctrl_i,
  input  logic                div_start_i,
  input  logic                div_step_i,
  output logic [PixW-1:0]     mean_o
);

  logic [PowW-1:0] mem_q [TblDepth];
  logic [PowW-1:0] w_q;
  logic [PixW-1:0] p_q;
  logic            s1_q;
  logic [PowW+PixW-1:0] prod_q;
  logic [PowW-1:0]      w2_q;
  logic            s2_q;
  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic [NumW:0]   nsum;
  logic [DenW:0]   dsum;
  // Divider: remainder and quotient (9 bits detects values above 255).
  logic [NumW-1:0] rem_q, rem_d;
  logic [NumW-1:0] dvd_q;
  logic [PixW:0]   quo_q;
  logic            ovf_q;
  logic [DenW-1:0] dvs_q;
  logic [NumW:0]   trial;

  always_ff @(posedge clk_i) begin
    if (tbl_we_i) begin
      mem_q[tbl_idx_i] <= tbl_val_i;
    end
    w_q <= mem_q[pix_i];
    p_q <= pix_i;
    prod_q <= p_q * w_q;
    w2_q <= w_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      s1_q <= pix_v_i && ctrl_i.lane_en;
      s2_q <= s1_q;
    end
  end

  assign nsum = {1'b0, num_q} + {{(NumW+1-PowW-PixW){1'b0}}, prod_q};
  assign dsum = {1'b0, den_q} + {{(DenW+1-PowW){1'b0}}, w2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0;
      den_q <= '0;
    end else if (ctrl_i.clear) begin
      num_q <= '0;
      den_q <= '0;
    end else if (s2_q) begin
      num_q <= nsum[NumW] ? '1 : nsum[NumW-1:0];
      den_q <= dsum[DenW] ? '1 : dsum[DenW-1:0];
    end
  end

  // Quotient is formed MSB first over 9 bit positions; any set bit above
  // those means the quotient exceeds 255 and saturates.
  assign trial = {rem_q, dvd_q[NumW-1]} - {{(NumW+1-DenW){1'b0}}, dvs_q};
  assign rem_d = trial[NumW] ? {rem_q[NumW-2:0], dvd_q[NumW-1]} : trial[NumW-1:0];

  always_ff @(posedge clk_i) begin
    if (div_start_i) begin
      dvs_q <= den_q;
      ovf_q <= ({1'b0, num_q >> (PixW+1)} >= {{(NumW+1-DenW){1'b0}}, den_q});
      rem_q <= num_q >> (PixW+1);
      dvd_q <= num_q << (NumW-PixW-1);
      quo_q <= '0;
    end else if (div_step_i) begin
      rem_q <= rem_d;
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[PixW-1:0], ~trial[NumW]};
    end
  end

  always_comb begin
    if (!ctrl_i.lane_en || dvs_q == '0) begin
      mean_o = '0;
    end else if (ovf_q || quo_q[PixW]) begin
      mean_o = '1;
    end else begin
      mean_o = quo_q[PixW-1:0];
    end
  end

endmodule

/* src/contraharmonic_mean_accumulator_top.sv */
// Contraharmonic mean accumulator: top level with lanes and merge stage.
//
// Channels: in_if carries pixels (req_type 0) and power table writes
// (req_type 1); out_if delivers one result of four 8-bit means per window;
// cfg_if writes channels_in_use (1..4, larger counts act as four, 0 enables no lane).
// Table writes and non-final pixels are taken one per cycle while the
// block accumulates. On the pixel that ends a window the block waits for
// its two-stage lookup and product pipeline to reach the sums, then runs
// one restoring divider per lane, one quotient bit per cycle. Then the
// result is registered at the output once the output register is free,
// the sums are cleared with it, and the block takes requests again.
// Reset clears the sums, the output valid flag and sets channels_in_use to
// one; the power table holds no defined values until written. When the
// receiver stalls the result is held; requests are still taken until the
// next window ends, and its result then waits for the output register.
module contraharmonic_mean_accumulator_top import chm_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  chm_in_if.sink   in_if,
  chm_cfg_if.sink  cfg_if,
  chm_out_if.source out_if
);

  localparam int unsigned DrainCyc = 3;
  localparam int unsigned DivCyc   = PixW + 1;

  div_state_e      state_q, state_d;
  logic [CfgW-1:0] chn_q;
  logic [3:0]      cnt_q, cnt_d;
  logic            ovalid_q;
  logic [PixW-1:0] mean_q [NumLanes];
  logic [PixW-1:0] lane_mean [NumLanes];
  logic            acc, pix_v, div_start, div_step, clear;
  logic [PixW-1:0] samples [NumLanes];
  logic [CfgW-1:0] nact;

  assign cfg_if.ready = 1'b1;
  assign nact = (chn_q > CfgW'(MAX_CHANNELS)) ? CfgW'(MAX_CHANNELS) : chn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chn_q <= CfgW'(1);
    end else if (cfg_if.valid) begin
      chn_q <= cfg_if.data;
    end
  end

  assign in_if.ready = (state_q == ST_ACCUM);
  assign acc   = in_if.valid && in_if.ready;
  assign pix_v = acc && (in_if.req_type == REQ_PIXEL);
  assign samples[0] = in_if.sample_ch0;
  assign samples[1] = in_if.sample_ch1;
  assign samples[2] = in_if.sample_ch2;
  assign samples[3] = in_if.sample_ch3;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    div_start = 1'b0;
    div_step  = 1'b0;
    clear     = 1'b0;
    unique case (state_q)
      ST_ACCUM: begin
        if (pix_v && in_if.window_end) begin
          state_d = ST_DIVIDE;
          cnt_d   = '0;
        end
      end
      ST_DIVIDE: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(DrainCyc)) begin
          div_start = 1'b1;
        end else if (cnt_q > 4'(DrainCyc)) begin
          div_step = 1'b1;
        end
        if (cnt_q == 4'(DrainCyc + DivCyc)) begin
          state_d = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (!ovalid_q || out_if.ready) begin
          clear   = 1'b1;
          state_d = ST_ACCUM;
        end
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    lane_ctrl_t ctrl;
    assign ctrl.lane_en = (CfgW'(g) < nact);
    assign ctrl.clear   = clear;
    chm_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tbl_we_i   (acc && (in_if.req_type == REQ_TABLE)),
      .tbl_idx_i  (in_if.table_index),
      .tbl_val_i  (in_if.table_value),
      .pix_v_i    (pix_v),
      .pix_i      (samples[g]),
      .ctrl_i     (ctrl),
      .div_start_i(div_start),
      .div_step_i (div_step),
      .mean_o     (lane_mean[g])
    );
  end

  // Merge stage: the lane quotients are registered together as one result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (clear) begin
      ovalid_q <= 1'b1;
    end else if (out_if.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear) begin
      mean_q <= lane_mean;
    end
  end

  assign out_if.valid    = ovalid_q;
  assign out_if.mean_ch0 = mean_q[0];
  assign out_if.mean_ch1 = mean_q[1];
  assign out_if.mean_ch2 = mean_q[2];
  assign out_if.mean_ch3 = mean_q[3];

endmodule
